[rtl/rru_pkg.sv]
// Types and constants shared by the reflect/refract unit.
package rru_pkg;

    typedef struct packed {
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        index_from;
        logic [15:0]        index_to;
    } rru_in_t;

    typedef struct packed {
        logic signed [15:0] reflect_x;
        logic signed [15:0] reflect_y;
        logic signed [15:0] reflect_z;
        logic signed [15:0] refract_x;
        logic signed [15:0] refract_y;
        logic signed [15:0] refract_z;
        logic               total_reflection;
        logic               degenerate;
    } rru_out_t;

    // root unit: 64-bit radicand, one result bit per stage
    localparam int SQRT_W   = 64;
    localparam int SQRT_LAT = SQRT_W / 2;

    // normalising divide: |c| * 2^46 / S
    localparam int NDIV_N_W = 62;
    localparam int NDIV_D_W = 32;
    localparam int NDIV_Q_W = 31;

    // radicand divide: (lhs - rhs) / n2^2
    localparam int KDIV_N_W = 62;
    localparam int KDIV_D_W = 32;
    localparam int KDIV_Q_W = 31;

    // eta scaling divide: |a| * n1 / n2
    localparam int EDIV_N_W = 48;
    localparam int EDIV_D_W = 16;
    localparam int EDIV_Q_W = 48;

    localparam int Q30_FRAC = 30;
    localparam logic signed [63:0] OUT_MAX = 64'sd32767;
    localparam logic signed [63:0] OUT_MIN = -64'sd32768;

endpackage

[rtl/rru_delay.sv]
// Enabled delay line for sideband data.
module rru_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d_in;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign d_out = pipe_reg[DEPTH-1];

endmodule

[rtl/rru_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module rru_isqrt #(
    parameter int RAD_W = 64
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [RAD_W-1:0]   rad_in,
    output logic [RAD_W/2-1:0] root_out
);

    localparam int STAGES = RAD_W / 2;

    logic [RAD_W-1:0] v_reg [STAGES];
    logic [RAD_W-1:0] r_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * s);
        logic [RAD_W-1:0] v_in, r_in, trial, v_next, r_next;
        logic             take;

        if (s == 0) begin : g_first
            assign v_in = rad_in;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = v_reg[s-1];
            assign r_in = r_reg[s-1];
        end

        assign trial  = r_in + BIT;
        assign take   = (v_in >= trial);
        assign v_next = take ? v_in - trial : v_in;
        assign r_next = take ? (r_in >> 1) + BIT : (r_in >> 1);

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[s] <= v_next;
                r_reg[s] <= r_next;
            end
        end
    end

    assign root_out = r_reg[STAGES-1][RAD_W/2-1:0];

endmodule

[rtl/rru_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
module rru_div #(
    parameter int N_W = 62,
    parameter int D_W = 32,
    parameter int Q_W = 31
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [N_W-1:0] num_in,
    input  logic [D_W-1:0] den_in,
    output logic [Q_W-1:0] quo_out
);

    localparam int W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [N_W-1:0] rem_reg [Q_W];
    logic [D_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0] quo_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int K = Q_W - 1 - s;
        logic [N_W-1:0] rem_in;
        logic [D_W-1:0] d_in;
        logic [Q_W-1:0] q_in;
        logic [W-1:0]   trial, rem_w, rem_next;
        logic           take;

        if (s == 0) begin : g_first
            assign rem_in = num_in;
            assign d_in   = den_in;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign d_in   = den_reg[s-1];
            assign q_in   = quo_reg[s-1];
        end

        assign trial    = W'(d_in) << K;
        assign rem_w    = W'(rem_in);
        assign take     = (rem_w >= trial);
        assign rem_next = take ? rem_w - trial : rem_w;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next[N_W-1:0];
                den_reg[s] <= d_in;
                quo_reg[s] <= {q_in[Q_W-2:0], take};
            end
        end
    end

    assign quo_out = quo_reg[Q_W-1];

endmodule

[rtl/reflect_refract_unit.sv]
// Reflect/refract unit top level: normalise, reflect, Snell refraction.
//
//  channel | ports              | payload
//  --------+--------------------+-------------------
//  input   | s_valid, s_ready   | s_data  (rru_in_t)
//  result  | m_valid, m_ready   | m_data  (rru_out_t)
//
// One transfer per cycle sustained while the result register is empty or taken;
// input to result passes two root units and two divider chains in series.
// Synchronous active-low reset clears the valid pipeline only.
// The whole pipeline advances while the result register is empty or taken;
// s_ready is that same enable.
module reflect_refract_unit #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rru_pkg::rru_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rru_pkg::rru_out_t m_data
);

    localparam int SH       = rru_pkg::Q30_FRAC - OUT_FRAC_BITS;
    localparam int RAW_DLY  = 1 + rru_pkg::SQRT_LAT;
    localparam int SGN_DLY  = rru_pkg::NDIV_Q_W;
    localparam int SIDE_DLY = rru_pkg::SQRT_LAT + rru_pkg::NDIV_Q_W + 5;
    localparam int N_DLY    = 2 + rru_pkg::KDIV_Q_W + rru_pkg::SQRT_LAT;
    localparam int ASG_DLY  = 1 + rru_pkg::KDIV_Q_W + rru_pkg::SQRT_LAT;
    localparam int EA_DLY   = ASG_DLY - rru_pkg::EDIV_Q_W;
    localparam int TAIL_DLY = rru_pkg::KDIV_Q_W + rru_pkg::SQRT_LAT;
    localparam int LAT      = 2 + rru_pkg::SQRT_LAT + rru_pkg::NDIV_Q_W + 5 + 2
                              + rru_pkg::KDIV_Q_W + rru_pkg::SQRT_LAT + 2;

    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                    input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = m >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = trunc_shr(v, SH);
        if (t > rru_pkg::OUT_MAX) begin
            t = rru_pkg::OUT_MAX;
        end else if (t < rru_pkg::OUT_MIN) begin
            t = rru_pkg::OUT_MIN;
        end
        return t[15:0];
    endfunction

    logic             en;
    logic [LAT-1:0]   vld_reg, vld_next;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_comb begin
        vld_next = {vld_reg[LAT-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: squares
    logic signed [15:0] l_raw_reg [3], l_raw_next [3];
    logic signed [15:0] n_raw_reg [3], n_raw_next [3];
    logic [30:0]        sql_reg [3], sql_next [3];
    logic [30:0]        sqn_reg [3], sqn_next [3];
    logic [15:0]        n1_1_reg, n2_1_reg;
    logic [31:0]        n1sq_1_reg, n1sq_1_next, n2sq_1_reg, n2sq_1_next;

    always_comb begin
        logic signed [31:0] p;
        l_raw_next[0] = s_data.incident_x;
        l_raw_next[1] = s_data.incident_y;
        l_raw_next[2] = s_data.incident_z;
        n_raw_next[0] = s_data.normal_x;
        n_raw_next[1] = s_data.normal_y;
        n_raw_next[2] = s_data.normal_z;
        for (int i = 0; i < 3; i++) begin
            p           = l_raw_next[i] * l_raw_next[i];
            sql_next[i] = p[30:0];
            p           = n_raw_next[i] * n_raw_next[i];
            sqn_next[i] = p[30:0];
        end
        n1sq_1_next = s_data.index_from * s_data.index_from;
        n2sq_1_next = s_data.index_to * s_data.index_to;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_raw_reg  <= l_raw_next;
            n_raw_reg  <= n_raw_next;
            sql_reg    <= sql_next;
            sqn_reg    <= sqn_next;
            n1_1_reg   <= s_data.index_from;
            n2_1_reg   <= s_data.index_to;
            n1sq_1_reg <= n1sq_1_next;
            n2sq_1_reg <= n2sq_1_next;
        end
    end

    // stage 2: squared lengths
    logic [31:0] len2_l_reg, len2_l_next, len2_n_reg, len2_n_next;
    logic [15:0] n1_2_reg, n2_2_reg;
    logic [31:0] n1sq_2_reg, n2sq_2_reg;
    logic        deg2;

    always_comb begin
        len2_l_next = 32'(sql_reg[0]) + 32'(sql_reg[1]) + 32'(sql_reg[2]);
        len2_n_next = 32'(sqn_reg[0]) + 32'(sqn_reg[1]) + 32'(sqn_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len2_l_reg <= len2_l_next;
            len2_n_reg <= len2_n_next;
            n1_2_reg   <= n1_1_reg;
            n2_2_reg   <= n2_1_reg;
            n1sq_2_reg <= n1sq_1_reg;
            n2sq_2_reg <= n2sq_1_reg;
        end
    end

    assign deg2 = (len2_l_reg == '0) || (len2_n_reg == '0);

    // lengths
    logic [31:0] s_l, s_n;

    rru_isqrt #(.RAD_W(rru_pkg::SQRT_W)) u_sqrt_l (
        .aclk(aclk), .en(en), .rad_in({len2_l_reg, 32'd0}), .root_out(s_l)
    );
    rru_isqrt #(.RAD_W(rru_pkg::SQRT_W)) u_sqrt_n (
        .aclk(aclk), .en(en), .rad_in({len2_n_reg, 32'd0}), .root_out(s_n)
    );

    logic [95:0] raw_d;
    logic [5:0]  sgn_d;
    logic [5:0]  sgn34;

    rru_delay #(.W(96), .DEPTH(RAW_DLY)) u_raw_dly (
        .aclk(aclk), .en(en),
        .d_in({l_raw_reg[0], l_raw_reg[1], l_raw_reg[2],
               n_raw_reg[0], n_raw_reg[1], n_raw_reg[2]}),
        .d_out(raw_d)
    );

    for (genvar i = 0; i < 6; i++) begin : g_sgn
        assign sgn34[i] = raw_d[16*i+15];
    end

    rru_delay #(.W(6), .DEPTH(SGN_DLY)) u_sgn_dly (
        .aclk(aclk), .en(en), .d_in(sgn34), .d_out(sgn_d)
    );

    // normalising divides; lane i of raw_d: 0..2 normal z..x, 3..5 incident z..x
    logic [30:0] umag [6];

    for (genvar i = 0; i < 6; i++) begin : g_ndiv
        logic signed [15:0] c;
        logic [15:0]        cm;
        assign c  = raw_d[16*i +: 16];
        assign cm = c[15] ? 16'(-c) : 16'(c);
        rru_div #(
            .N_W(rru_pkg::NDIV_N_W), .D_W(rru_pkg::NDIV_D_W), .Q_W(rru_pkg::NDIV_Q_W)
        ) u_div (
            .aclk(aclk), .en(en),
            .num_in({cm, 46'd0}),
            .den_in(i < 3 ? s_n : s_l),
            .quo_out(umag[i])
        );
    end

    // side data to stage 70
    logic [96:0] side70;
    logic        deg70;
    logic [15:0] n1_70, n2_70;
    logic [31:0] n1sq_70, n2sq_70;

    rru_delay #(.W(97), .DEPTH(SIDE_DLY)) u_side_dly (
        .aclk(aclk), .en(en),
        .d_in({deg2, n1_2_reg, n2_2_reg, n1sq_2_reg, n2sq_2_reg}),
        .d_out(side70)
    );
    assign {deg70, n1_70, n2_70, n1sq_70, n2sq_70} = side70;

    // stage 66: signed unit vectors
    logic signed [31:0] l66_reg [3], l66_next [3], n66_reg [3], n66_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            l66_next[i] = sgn_d[5-i] ? -$signed({1'b0, umag[5-i]})
                                     : $signed({1'b0, umag[5-i]});
            n66_next[i] = sgn_d[2-i] ? -$signed({1'b0, umag[2-i]})
                                     : $signed({1'b0, umag[2-i]});
        end
    end

    // stage 67: lane products
    logic signed [63:0] nl67_reg [3], nl67_next [3];
    logic signed [31:0] l67_reg [3], n67_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nl67_next[i] = n66_reg[i] * l66_reg[i];
        end
    end

    // stage 68: dot product
    logic signed [63:0] d68_reg, d68_next;
    logic signed [31:0] l68_reg [3], n68_reg [3];

    always_comb begin
        d68_next = trunc_shr(nl67_reg[0] + nl67_reg[1] + nl67_reg[2], rru_pkg::Q30_FRAC);
    end

    // stage 69: d*N and d*d
    logic signed [63:0] dn69_reg [3], dn69_next [3], dd69_reg, dd69_next;
    logic signed [31:0] l69_reg [3], n69_reg [3];

    always_comb begin
        logic signed [31:0] d;
        d = d68_reg[31:0];
        for (int i = 0; i < 3; i++) begin
            dn69_next[i] = d * n68_reg[i];
        end
        dd69_next = d * d;
    end

    // stage 70: reflection, cosine term, refraction lane term
    logic signed [15:0] refl70_reg [3], refl70_next [3];
    logic signed [63:0] a70_reg [3], a70_next [3];
    logic [30:0]        c70_reg, c70_next;
    logic signed [31:0] n70_reg [3];

    always_comb begin
        logic signed [63:0] cc;
        for (int i = 0; i < 3; i++) begin
            refl70_next[i] = to_out(trunc_shr(dn69_reg[i], rru_pkg::Q30_FRAC - 1)
                                    - 64'(l69_reg[i]));
            a70_next[i]    = trunc_shr(dn69_reg[i], rru_pkg::Q30_FRAC) - 64'(l69_reg[i]);
        end
        cc = (64'sd1 <<< rru_pkg::Q30_FRAC) - trunc_shr(dd69_reg, rru_pkg::Q30_FRAC);
        c70_next = cc[63] ? '0 : cc[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l66_reg    <= l66_next;
            n66_reg    <= n66_next;
            nl67_reg   <= nl67_next;
            l67_reg    <= l66_reg;
            n67_reg    <= n66_reg;
            d68_reg    <= d68_next;
            l68_reg    <= l67_reg;
            n68_reg    <= n67_reg;
            dn69_reg   <= dn69_next;
            dd69_reg   <= dd69_next;
            l69_reg    <= l68_reg;
            n69_reg    <= n68_reg;
            refl70_reg <= refl70_next;
            a70_reg    <= a70_next;
            c70_reg    <= c70_next;
            n70_reg    <= n69_reg;
        end
    end

    // stage 71: radicand terms, eta numerators
    logic [62:0]        rhs71_reg, rhs71_next;
    logic [61:0]        lhs71_reg, lhs71_next;
    logic [47:0]        pa71_reg [3], pa71_next [3];
    logic [2:0]         asg71_reg, asg71_next;
    logic               n2z71_reg, deg71_reg;
    logic [15:0]        n2_71_reg;
    logic [31:0]        n2sq71_reg;
    logic signed [15:0] refl71_reg [3];

    always_comb begin
        logic [31:0] am;
        rhs71_next = n1sq_70 * c70_reg;
        lhs71_next = {n2sq_70, 30'd0};
        for (int i = 0; i < 3; i++) begin
            am            = a70_reg[i][63] ? 32'(-a70_reg[i]) : a70_reg[i][31:0];
            pa71_next[i]  = am * n1_70;
            asg71_next[i] = a70_reg[i][63];
        end
    end

    // stage 72: total reflection test and radicand numerator
    logic               tir72_reg, tir72_next, deg72_reg;
    logic [61:0]        diff72_reg, diff72_next;
    logic [31:0]        n2sq72_reg;
    logic signed [15:0] refl72_reg [3];

    always_comb begin
        logic [62:0] df;
        tir72_next  = n2z71_reg || (rhs71_reg > {1'b0, lhs71_reg});
        df          = {1'b0, lhs71_reg} - rhs71_reg;
        diff72_next = df[61:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rhs71_reg  <= rhs71_next;
            lhs71_reg  <= lhs71_next;
            pa71_reg   <= pa71_next;
            asg71_reg  <= asg71_next;
            n2z71_reg  <= (n2_70 == '0);
            deg71_reg  <= deg70;
            n2_71_reg  <= n2_70;
            n2sq71_reg <= n2sq_70;
            refl71_reg <= refl70_reg;
            tir72_reg  <= tir72_next;
            diff72_reg <= diff72_next;
            n2sq72_reg <= n2sq71_reg;
            deg72_reg  <= deg71_reg;
            refl72_reg <= refl71_reg;
        end
    end

    // radicand and its root
    logic [30:0] k103;
    logic [31:0] root135;

    rru_div #(
        .N_W(rru_pkg::KDIV_N_W), .D_W(rru_pkg::KDIV_D_W), .Q_W(rru_pkg::KDIV_Q_W)
    ) u_kdiv (
        .aclk(aclk), .en(en), .num_in(diff72_reg), .den_in(n2sq72_reg), .quo_out(k103)
    );

    rru_isqrt #(.RAD_W(rru_pkg::SQRT_W)) u_sqrt_k (
        .aclk(aclk), .en(en), .rad_in({3'd0, k103, 30'd0}), .root_out(root135)
    );

    // eta scaling
    logic [47:0] ea_q [3];
    logic [47:0] ea135 [3];

    for (genvar i = 0; i < 3; i++) begin : g_ediv
        rru_div #(
            .N_W(rru_pkg::EDIV_N_W), .D_W(rru_pkg::EDIV_D_W), .Q_W(rru_pkg::EDIV_Q_W)
        ) u_div (
            .aclk(aclk), .en(en), .num_in(pa71_reg[i]), .den_in(n2_71_reg),
            .quo_out(ea_q[i])
        );
        rru_delay #(.W(48), .DEPTH(EA_DLY)) u_ea_dly (
            .aclk(aclk), .en(en), .d_in(ea_q[i]), .d_out(ea135[i])
        );
    end

    logic [2:0]  asg135;
    logic [95:0] n135;
    logic [49:0] tail135;

    rru_delay #(.W(3), .DEPTH(ASG_DLY)) u_asg_dly (
        .aclk(aclk), .en(en), .d_in(asg71_reg), .d_out(asg135)
    );
    rru_delay #(.W(96), .DEPTH(N_DLY)) u_n_dly (
        .aclk(aclk), .en(en), .d_in({n70_reg[0], n70_reg[1], n70_reg[2]}), .d_out(n135)
    );
    rru_delay #(.W(50), .DEPTH(TAIL_DLY)) u_tail_dly (
        .aclk(aclk), .en(en),
        .d_in({refl72_reg[0], refl72_reg[1], refl72_reg[2], tir72_reg, deg72_reg}),
        .d_out(tail135)
    );

    // stage 136: root*N and signed eta term
    logic signed [63:0] rn136_reg [3], rn136_next [3];
    logic signed [63:0] ea136_reg [3], ea136_next [3];
    logic [49:0]        tail136_reg;

    always_comb begin
        logic signed [31:0] nn;
        for (int i = 0; i < 3; i++) begin
            nn            = n135[32*(2-i) +: 32];
            rn136_next[i] = $signed({1'b0, root135}) * nn;
            ea136_next[i] = asg135[i] ? -$signed({16'd0, ea135[i]})
                                      : $signed({16'd0, ea135[i]});
        end
    end

    // stage 137: result register
    rru_pkg::rru_out_t out_reg, out_next;

    always_comb begin
        logic signed [15:0] t [3];
        logic               tir, deg;
        tir = tail136_reg[1];
        deg = tail136_reg[0];
        for (int i = 0; i < 3; i++) begin
            t[i] = to_out(ea136_reg[i] - trunc_shr(rn136_reg[i], rru_pkg::Q30_FRAC));
            if (tir || deg) begin
                t[i] = '0;
            end
        end
        out_next.reflect_x        = deg ? '0 : tail136_reg[49:34];
        out_next.reflect_y        = deg ? '0 : tail136_reg[33:18];
        out_next.reflect_z        = deg ? '0 : tail136_reg[17:2];
        out_next.refract_x        = t[0];
        out_next.refract_y        = t[1];
        out_next.refract_z        = t[2];
        out_next.total_reflection = tir && !deg;
        out_next.degenerate       = deg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rn136_reg   <= rn136_next;
            ea136_reg   <= ea136_next;
            tail136_reg <= tail135;
            out_reg     <= out_next;
        end
    end

    assign m_data = out_reg;

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> !m_data.total_reflection
            && m_data.reflect_x == 0 && m_data.reflect_y == 0 && m_data.reflect_z == 0
            && m_data.refract_x == 0 && m_data.refract_y == 0 && m_data.refract_z == 0)
        else $error("degenerate result not cleared");

    a_tir_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.total_reflection |->
            m_data.refract_x == 0 && m_data.refract_y == 0 && m_data.refract_z == 0)
        else $error("refraction not cleared on total reflection");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

[sim/rru_checker.sv]
// Result checker for the reflect/refract unit: predicts each result and compares it.
`timescale 1ns / 100ps
module rru_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  rru_pkg::rru_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rru_pkg::rru_out_t m_data,
    output int                fail_count,
    output int                pending
);

    localparam int FRAC_OUT = 14;

    rru_pkg::rru_out_t expected_q[$];

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        m = magnitude(v) >> s;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat_out(input logic signed [63:0] q30);
        logic signed [63:0] v;
        v = shr_tz(q30, 30 - FRAC_OUT);
        if (v > rru_pkg::OUT_MAX) v = rru_pkg::OUT_MAX;
        if (v < rru_pkg::OUT_MIN) v = rru_pkg::OUT_MIN;
        return v[15:0];
    endfunction

    // unit vector in Q1.30; returns 0 on zero length
    function automatic bit to_unit(input logic signed [15:0] a, input logic signed [15:0] b,
                                   input logic signed [15:0] c,
                                   output logic signed [63:0] u[3]);
        logic signed [63:0] raw[3];
        logic [63:0] len2;
        logic [63:0] s;
        raw[0] = a;
        raw[1] = b;
        raw[2] = c;
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += raw[i] * raw[i];
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (len2 == 0) return 0;
        s = root64(len2 << 32);
        for (int i = 0; i < 3; i++) begin
            u[i] = $signed((magnitude(raw[i]) << 46) / s);
            if (raw[i] < 0) u[i] = -u[i];
        end
        return 1;
    endfunction

    function automatic rru_pkg::rru_out_t reflect_refract(input rru_pkg::rru_in_t x);
        rru_pkg::rru_out_t r;
        logic signed [63:0] l[3];
        logic signed [63:0] n[3];
        logic signed [63:0] d, c, sum, a, ea, t;
        logic [63:0] n1, n2, lhs, rhs, kval, root;
        bit ok_l, ok_n, tir;
        r = '0;
        ok_l = to_unit(x.incident_x, x.incident_y, x.incident_z, l);
        ok_n = to_unit(x.normal_x, x.normal_y, x.normal_z, n);
        if (!ok_l || !ok_n) begin
            r.degenerate = 1'b1;
            return r;
        end
        n1 = x.index_from;
        n2 = x.index_to;
        sum = 0;
        for (int i = 0; i < 3; i++) sum += n[i] * l[i];
        d = shr_tz(sum, 30);
        r.reflect_x = sat_out(shr_tz(2 * d * n[0], 30) - l[0]);
        r.reflect_y = sat_out(shr_tz(2 * d * n[1], 30) - l[1]);
        r.reflect_z = sat_out(shr_tz(2 * d * n[2], 30) - l[2]);
        c = (64'sd1 <<< 30) - shr_tz(d * d, 30);
        if (c < 0) c = 0;
        tir  = 0;
        root = 0;
        if (n2 == 0) begin
            tir = 1;
        end else begin
            lhs = n2 * n2 * (64'd1 << 30);
            rhs = n1 * n1 * c;
            if (rhs > lhs) begin
                tir = 1;
            end else begin
                kval = (lhs - rhs) / (n2 * n2);
                root = root64(kval << 30);
            end
        end
        if (tir) begin
            r.total_reflection = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            a  = shr_tz(d * n[i], 30) - l[i];
            ea = $signed((magnitude(a) * n1) / n2);
            if (a < 0) ea = -ea;
            t  = ea - shr_tz($signed(root) * n[i], 30);
            case (i)
                0: r.refract_x = sat_out(t);
                1: r.refract_y = sat_out(t);
                default: r.refract_z = sat_out(t);
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge aclk) begin
        rru_pkg::rru_out_t e;
        if (aresetn && s_valid && s_ready) expected_q.push_back(reflect_refract(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                e = expected_q.pop_front();
                if (m_data.reflect_x !== e.reflect_x)
                    report_mismatch("reflect_x", m_data.reflect_x, e.reflect_x);
                if (m_data.reflect_y !== e.reflect_y)
                    report_mismatch("reflect_y", m_data.reflect_y, e.reflect_y);
                if (m_data.reflect_z !== e.reflect_z)
                    report_mismatch("reflect_z", m_data.reflect_z, e.reflect_z);
                if (m_data.refract_x !== e.refract_x)
                    report_mismatch("refract_x", m_data.refract_x, e.refract_x);
                if (m_data.refract_y !== e.refract_y)
                    report_mismatch("refract_y", m_data.refract_y, e.refract_y);
                if (m_data.refract_z !== e.refract_z)
                    report_mismatch("refract_z", m_data.refract_z, e.refract_z);
                if (m_data.total_reflection !== e.total_reflection)
                    report_mismatch("total_reflection", m_data.total_reflection,
                                    e.total_reflection);
                if (m_data.degenerate !== e.degenerate)
                    report_mismatch("degenerate", m_data.degenerate, e.degenerate);
            end
        end
        pending = expected_q.size();
    end
endmodule

[sim/testbench.sv]
// Testbench top for the reflect/refract unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

    localparam int LATENCY = 137;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    rru_pkg::rru_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 0;
    rru_pkg::rru_out_t m_data;
    int                fail_count;
    int                pending;
    bit                calm = 0;
    bit                stall_rx = 0;

    always #5 aclk = ~aclk;

    reflect_refract_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rru_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic rru_pkg::rru_in_t random_item();
        rru_pkg::rru_in_t x;
        x = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: begin
                x.incident_x = edge_value(); x.incident_y = edge_value();
                x.incident_z = edge_value(); x.normal_x = edge_value();
                x.normal_y = edge_value(); x.normal_z = edge_value();
                x.index_from = edge_value(); x.index_to = edge_value();
            end
            1: {x.incident_x, x.incident_y, x.incident_z} = '0;
            2: {x.normal_x, x.normal_y, x.normal_z} = '0;
            3: begin
                // small incident x and normal z, indices from 16000 to 33000
                x.incident_x = 16'($signed(16'($urandom_range(0, 64))) - 32);
                x.normal_z = 16'($signed(16'($urandom_range(0, 8))) - 4);
                x.index_from = 16'($urandom_range(16000, 33000));
                x.index_to = 16'($urandom_range(16000, 33000));
            end
            4: x.index_to = 16'($urandom_range(0, 3));
            5: x.index_from = 16'($urandom_range(0, 3));
            6: begin
                x.index_from = 16'($urandom_range(20000, 65535));
                x.index_to = 16'($urandom_range(16384, 24000));
            end
            default: ;
        endcase
        return x;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(input rru_pkg::rru_in_t x);
        if (!calm) begin
            while ($urandom_range(0, 99) < 33) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // receiver
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_rx) m_ready <= 1'b0;
            else if (calm) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin
        rru_pkg::rru_in_t x;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes and special cases
        x = '0; x.index_from = 16384; x.index_to = 16384;
        send(x);
        x.incident_z = 16'sh1000; x.normal_z = 16'sh1000;
        send(x);
        x.incident_x = 16'sh1000; send(x);
        x.index_from = 16'hffff; x.index_to = 16'd1; send(x);
        x.index_from = 0; x.index_to = 16384; send(x);
        x.index_from = 16384; x.index_to = 0; send(x);
        x.index_from = 16'hffff; x.index_to = 16'hffff; send(x);
        x = {16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0001, 16'hffff};
        send(x);
        x = {16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'h0001};
        send(x);
        x = {16'h0001, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'd16384, 16'd16384};
        send(x);
        x = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff};
        send(x);
        // grazing incidence into a denser-to-thinner boundary: TIR
        x = {16'h1000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h1000, 16'd24576, 16'd16384};
        send(x);
        // equal indices: radicand exactly d^2
        x = {16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'd32768, 16'd32768};
        send(x);

        // random, calm stretch in the middle
        for (int i = 0; i < 1100; i++) begin
            calm = (i >= 400 && i < 550);
            if (i == 700) begin
                // long receiver hold-off while offering items
                stall_rx = 1;
                fork
                    begin
                        repeat (400) @(posedge aclk);
                        stall_rx = 0;
                    end
                join_none
            end
            if (i == 900) begin
                s_valid <= 1'b0;
                wait (pending == 0 && !stall_rx);
                @(negedge aclk);
            end
            send(random_item());
        end
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
